FILE: rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, codes and types of the first-fit bitmap block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int MAX_BLOCKS = 2048;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 11;
    localparam int CNT_W  = 12;
    localparam int ST_W   = 2;

    localparam int WORD_W = 64;
    localparam int WBIT_W = $clog2(WORD_W);
    localparam int NWORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int LIM_W  = CNT_W - WBIT_W + 1;
    localparam int CMP_W  = (ADDR_W + 1 > LIM_W) ? ADDR_W + 1 : LIM_W;

    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
    localparam int               FREE_RST_I = (MAX_BLOCKS < 2048) ? MAX_BLOCKS : 2048;
    localparam logic [CNT_W-1:0] FREE_RST = CNT_W'(FREE_RST_I);
    localparam logic [CNT_W-1:0] TOTAL_RST = CNT_W'(2048);

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FORMAT = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_EV,
        S_RESP
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              clr;
    } t_bm_req;

    function automatic logic [WBIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
        logic [WBIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = WBIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/ffa_if.sv
// ----------------------------------------------------------------------------
// ffa_if
// Valid/ready channels of the allocator: command in, response out, config.
// ----------------------------------------------------------------------------
interface ffa_in_if;
    logic                       valid;
    logic                       ready;
    logic [ffa_pkg::CMD_W-1:0]  cmd;
    logic [ffa_pkg::IDX_W-1:0]  block_index;

    modport source (output valid, cmd, block_index, input ready);
    modport sink   (input valid, cmd, block_index, output ready);
endinterface

interface ffa_out_if;
    logic                       valid;
    logic                       ready;
    logic [ffa_pkg::ST_W-1:0]   status;
    logic [ffa_pkg::IDX_W-1:0]  granted_block;
    logic [ffa_pkg::CNT_W-1:0]  used_blocks;
    logic [ffa_pkg::CNT_W-1:0]  free_blocks;

    modport source (output valid, status, granted_block, used_blocks, free_blocks,
                    input ready);
    modport sink   (input valid, status, granted_block, used_blocks, free_blocks,
                    output ready);
endinterface

interface ffa_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [ffa_pkg::CNT_W-1:0]  total_blocks;

    modport source (output valid, total_blocks, input ready);
    modport sink   (input valid, total_blocks, output ready);
endinterface

FILE: rtl/first_fit_bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_bitmap_block_allocator
// First-fit block allocator over a used/free bitmap with used/free counters.
// ----------------------------------------------------------------------------
// One command word is taken at a time; the next is accepted as soon as the
// response sits in the output register. The bitmap is 32 words of 64 bits in
// a RAM with a single registered read port, scanned one word per cycle. An
// allocate reads words from the lowest up and stops at the first one that
// holds a free block, or after ceil(count/64) words when no block is free,
// and reads none when the count is zero; a free reads one word and writes
// it back with the bit cleared if it was set; format, out-of-range free and unknown commands answer without reading it.
// Reset and format clear 32 word-valid flags at once: no clearing pass.
// total_blocks above 2048 is clamped; a write to it only takes effect for
// the scan range at once and for the free count at the next format.
// ----------------------------------------------------------------------------
module first_fit_bitmap_block_allocator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ffa_in_if.sink       i_in,
    ffa_out_if.source    o_out,
    ffa_cfg_if.sink      i_cfg
);

    ffa_pkg::t_state                r_state, n_state;
    logic [ffa_pkg::CNT_W-1:0]      r_total;
    logic [ffa_pkg::CNT_W-1:0]      r_used, n_used;
    logic [ffa_pkg::CNT_W-1:0]      r_free, n_free;
    logic [ffa_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [ffa_pkg::ADDR_W:0]       r_scan, n_scan;
    logic [ffa_pkg::ADDR_W-1:0]     r_ev_addr, n_ev_addr;
    logic                           r_ev_live, n_ev_live;
    logic [ffa_pkg::ST_W-1:0]       r_res_status, n_res_status;
    logic [ffa_pkg::IDX_W-1:0]      r_res_granted, n_res_granted;
    logic                           r_out_valid, n_out_valid;
    logic [ffa_pkg::ST_W-1:0]       r_out_status, n_out_status;
    logic [ffa_pkg::IDX_W-1:0]      r_out_granted, n_out_granted;
    logic [ffa_pkg::CNT_W-1:0]      r_out_used, n_out_used;
    logic [ffa_pkg::CNT_W-1:0]      r_out_free, n_out_free;

    ffa_pkg::t_bm_req               bm_req;
    logic [ffa_pkg::WORD_W-1:0]     rdata;

    logic [ffa_pkg::CNT_W-1:0]      cnt;
    logic [ffa_pkg::CNT_W-ffa_pkg::WBIT_W-1:0] full_words;
    logic [ffa_pkg::LIM_W-1:0]      lim;
    logic                           issue;
    logic [ffa_pkg::WORD_W-1:0]     mask;
    logic [ffa_pkg::WORD_W-1:0]     avail;
    logic                           found;
    logic [ffa_pkg::WBIT_W-1:0]     abit;
    logic [ffa_pkg::WBIT_W-1:0]     fbit;
    logic                           in_ready;
    logic                           accept_in;
    logic                           idx_ok;
    logic                           out_room;

    ffa_bitmap u_bitmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (bm_req),
        .o_rdata (rdata)
    );

    assign cnt = (int'(r_total) > ffa_pkg::MAX_BLOCKS)
               ? ffa_pkg::CNT_W'(ffa_pkg::MAX_BLOCKS) : r_total;
    assign full_words = cnt[ffa_pkg::CNT_W-1:ffa_pkg::WBIT_W];
    assign lim = ffa_pkg::LIM_W'(full_words)
               + ffa_pkg::LIM_W'(cnt[ffa_pkg::WBIT_W-1:0] != '0);
    assign issue = (r_state == ffa_pkg::S_SCAN)
                && (ffa_pkg::CMP_W'(r_scan) < ffa_pkg::CMP_W'(lim));

    always_comb begin
        if (ffa_pkg::CMP_W'(r_ev_addr) < ffa_pkg::CMP_W'(full_words)) begin
            mask = '1;
        end else if (ffa_pkg::CMP_W'(r_ev_addr) == ffa_pkg::CMP_W'(full_words)) begin
            mask = (ffa_pkg::WORD_W'(1) << cnt[ffa_pkg::WBIT_W-1:0])
                 - ffa_pkg::WORD_W'(1);
        end else begin
            mask = '0;
        end
    end

    assign avail = ~rdata & mask;
    assign found = |avail;
    assign abit  = ffa_pkg::first_set(avail);
    assign fbit  = r_idx[ffa_pkg::WBIT_W-1:0];

    assign in_ready  = (r_state == ffa_pkg::S_IDLE);
    assign accept_in = i_in.valid && in_ready;
    assign idx_ok    = ffa_pkg::CNT_W'(i_in.block_index) < cnt;
    assign out_room  = !r_out_valid || o_out.ready;

    assign i_in.ready           = in_ready;
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.granted_block  = r_out_granted;
    assign o_out.used_blocks    = r_out_used;
    assign o_out.free_blocks    = r_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffa_pkg::S_IDLE: begin
                if (accept_in) begin
                    if (i_in.cmd == ffa_pkg::CMD_ALLOC) begin
                        n_state = ffa_pkg::S_SCAN;
                    end else if (i_in.cmd == ffa_pkg::CMD_FREE && idx_ok) begin
                        n_state = ffa_pkg::S_FREE_RD;
                    end else begin
                        n_state = ffa_pkg::S_RESP;
                    end
                end
            end
            ffa_pkg::S_SCAN: begin
                if ((r_ev_live && found) || (!r_ev_live && !issue)) begin
                    n_state = ffa_pkg::S_RESP;
                end
            end
            ffa_pkg::S_FREE_RD: n_state = ffa_pkg::S_FREE_EV;
            ffa_pkg::S_FREE_EV: n_state = ffa_pkg::S_RESP;
            ffa_pkg::S_RESP: begin
                if (out_room) begin
                    n_state = ffa_pkg::S_IDLE;
                end
            end
            default: n_state = ffa_pkg::S_IDLE;
        endcase
    end

    // datapath and bitmap requests
    always_comb begin
        n_used        = r_used;
        n_free        = r_free;
        n_idx         = r_idx;
        n_scan        = r_scan;
        n_ev_addr     = r_ev_addr;
        n_ev_live     = r_ev_live;
        n_res_status  = r_res_status;
        n_res_granted = r_res_granted;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_status  = r_out_status;
        n_out_granted = r_out_granted;
        n_out_used    = r_out_used;
        n_out_free    = r_out_free;
        bm_req        = '0;

        case (r_state)
            ffa_pkg::S_IDLE: begin
                if (accept_in) begin
                    n_idx         = i_in.block_index;
                    n_scan        = '0;
                    n_ev_live     = 1'b0;
                    n_res_granted = '0;
                    n_res_status  = ffa_pkg::ST_BAD;
                    case (i_in.cmd)
                        ffa_pkg::CMD_FORMAT: begin
                            bm_req.clr   = 1'b1;
                            n_used       = '0;
                            n_free       = cnt;
                            n_res_status = ffa_pkg::ST_OK;
                        end
                        default: ;
                    endcase
                end
            end
            ffa_pkg::S_SCAN: begin
                bm_req.rd_en   = issue;
                bm_req.rd_addr = r_scan[ffa_pkg::ADDR_W-1:0];
                n_ev_live      = issue;
                n_ev_addr      = r_scan[ffa_pkg::ADDR_W-1:0];
                if (issue) begin
                    n_scan = r_scan + 1'b1;
                end
                if (r_ev_live && found) begin
                    bm_req.wr_en   = 1'b1;
                    bm_req.wr_addr = r_ev_addr;
                    bm_req.wr_data = rdata | (ffa_pkg::WORD_W'(1) << abit);
                    n_used         = (r_used < ffa_pkg::CNT_MAX) ? r_used + 1'b1 : r_used;
                    n_free         = (r_free != '0) ? r_free - 1'b1 : r_free;
                    n_res_status   = ffa_pkg::ST_OK;
                    n_res_granted  = ffa_pkg::IDX_W'({r_ev_addr, abit});
                end else if (!r_ev_live && !issue) begin
                    n_res_status  = ffa_pkg::ST_FULL;
                end
            end
            ffa_pkg::S_FREE_RD: begin
                bm_req.rd_en   = 1'b1;
                bm_req.rd_addr = ffa_pkg::ADDR_W'(r_idx >> ffa_pkg::WBIT_W);
            end
            ffa_pkg::S_FREE_EV: begin
                if (rdata[fbit]) begin
                    bm_req.wr_en   = 1'b1;
                    bm_req.wr_addr = ffa_pkg::ADDR_W'(r_idx >> ffa_pkg::WBIT_W);
                    bm_req.wr_data = rdata & ~(ffa_pkg::WORD_W'(1) << fbit);
                    n_used         = (r_used != '0) ? r_used - 1'b1 : r_used;
                    n_free         = (r_free < ffa_pkg::CNT_MAX) ? r_free + 1'b1 : r_free;
                    n_res_status   = ffa_pkg::ST_OK;
                end else begin
                    n_res_status   = ffa_pkg::ST_BAD;
                end
            end
            ffa_pkg::S_RESP: begin
                if (out_room) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_granted = r_res_granted;
                    n_out_used    = r_used;
                    n_out_free    = r_free;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffa_pkg::S_IDLE;
            r_total     <= ffa_pkg::TOTAL_RST;
            r_used      <= '0;
            r_free      <= ffa_pkg::FREE_RST;
            r_ev_live   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_free      <= n_free;
            r_ev_live   <= n_ev_live;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_total <= i_cfg.total_blocks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_scan        <= n_scan;
        r_ev_addr     <= n_ev_addr;
        r_res_status  <= n_res_status;
        r_res_granted <= n_res_granted;
        r_out_status  <= n_out_status;
        r_out_granted <= n_out_granted;
        r_out_used    <= n_out_used;
        r_out_free    <= n_out_free;
    end

endmodule

FILE: rtl/ffa_bitmap.sv
// ----------------------------------------------------------------------------
// ffa_bitmap
// In-use bitmap held as 64-bit words in a one-port-read, one-port-write RAM.
// A per-word valid flag makes unwritten words read as all free.
// ----------------------------------------------------------------------------
module ffa_bitmap (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffa_pkg::t_bm_req              i_req,
    output logic [ffa_pkg::WORD_W-1:0]    o_rdata
);

    logic [ffa_pkg::WORD_W-1:0] mem [ffa_pkg::NWORDS];
    logic [ffa_pkg::NWORDS-1:0] r_vld;
    logic [ffa_pkg::WORD_W-1:0] r_rdata;
    logic                       r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.clr) begin
                r_vld <= '0;
            end else if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

FILE: rtl/ffa_chk.sv
// ----------------------------------------------------------------------------
// ffa_chk
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffa_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [ffa_pkg::ST_W-1:0]   i_status,
    input logic [ffa_pkg::IDX_W-1:0]  i_granted,
    input logic [ffa_pkg::CNT_W-1:0]  i_used,
    input logic [ffa_pkg::CNT_W-1:0]  i_free
);

    // response word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_granted) && $stable(i_used) && $stable(i_free))
        else $error("response word changed while stalled");

    // one command word in flight
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while busy");

    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ffa_pkg::ST_OK |-> i_granted == '0)
        else $error("block number reported on failed command");

    // used count never more than the bitmap holds
    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> int'(i_used) <= ffa_pkg::MAX_BLOCKS)
        else $error("used count beyond bitmap size");

endmodule

bind first_fit_bitmap_block_allocator ffa_chk u_ffa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_granted   (o_out.granted_block),
    .i_used      (o_out.used_blocks),
    .i_free      (o_out.free_blocks)
);

FILE: dv/ffa_checker.sv
// ----------------------------------------------------------------------------
// ffa_checker
// Watches the command, response and config channels of the block allocator.
// Each accepted command word updates a private copy of the bitmap and the
// used/free counts and queues the response it must produce. Each accepted
// response word is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module ffa_checker
    import ffa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ffa_in_if    i_in,
    ffa_out_if   i_out,
    ffa_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] granted;
        logic [CNT_W-1:0] used;
        logic [CNT_W-1:0] free_cnt;
    } t_resp;

    logic [MAX_BLOCKS-1:0] block_used;
    logic [CNT_W-1:0]      used_total;
    logic [CNT_W-1:0]      free_total;
    logic [CNT_W-1:0]      block_count;
    t_resp                 expected_resp[$];

    function automatic t_resp run_command(input logic [CMD_W-1:0] cmd,
                                          input logic [IDX_W-1:0] idx);
        t_resp r;
        int    lim;
        bit    found;
        lim = (int'(block_count) > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_count);
        found = 1'b0;
        r = '0;
        r.status = ST_BAD;
        case (cmd)
            CMD_ALLOC: begin
                r.status = ST_FULL;
                for (int b = 0; b < lim; b++) begin
                    if (!found && !block_used[b]) begin
                        found = 1'b1;
                        block_used[b] = 1'b1;
                        r.granted = IDX_W'(b);
                        if (used_total != CNT_MAX) used_total = used_total + 1'b1;
                        if (free_total != '0) free_total = free_total - 1'b1;
                        r.status = ST_OK;
                    end
                end
            end
            CMD_FREE: begin
                if (int'(idx) < lim && block_used[idx]) begin
                    block_used[idx] = 1'b0;
                    if (used_total != '0) used_total = used_total - 1'b1;
                    if (free_total != CNT_MAX) free_total = free_total + 1'b1;
                    r.status = ST_OK;
                end
            end
            CMD_FORMAT: begin
                block_used = '0;
                used_total = '0;
                free_total = CNT_W'(lim);
                r.status = ST_OK;
            end
            default: begin
            end
        endcase
        r.used = used_total;
        r.free_cnt = free_total;
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_resp e;
        if (!i_rst_n) begin
            block_used = '0;
            used_total = '0;
            free_total = FREE_RST;
            block_count = TOTAL_RST;
            expected_resp.delete();
            o_errors = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                block_count = i_cfg.total_blocks;
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_resp.size() == 0) begin
                    $display("%0t ns: response word with none expected, actual %0d %0d %0d %0d",
                             $time, i_out.status, i_out.granted_block,
                             i_out.used_blocks, i_out.free_blocks);
                    o_errors++;
                end else begin
                    e = expected_resp.pop_front();
                    check_field("status", e.status, i_out.status);
                    check_field("granted_block", e.granted, i_out.granted_block);
                    check_field("used_blocks", e.used, i_out.used_blocks);
                    check_field("free_blocks", e.free_cnt, i_out.free_blocks);
                end
            end
            if (i_in.valid && i_in.ready) begin
                expected_resp.push_back(run_command(i_in.cmd, i_in.block_index));
            end
        end
        o_pending = expected_resp.size();
    end

endmodule

FILE: dv/tb_first_fit_bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_first_fit_bitmap_block_allocator
// Drives the block allocator with a directed set of commands covering the
// block count extremes, then random allocate/free/format/unknown traffic over a
// series of block counts with random stalls on both channels. Checking is
// done by ffa_checker; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_first_fit_bitmap_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import ffa_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam int NPHASES       = 12;
    localparam int PHASE_WORDS   = 120;
    localparam int STALL_CYCLES  = 300;

    logic clk = 1'b0;
    logic rst_n;

    ffa_in_if  in_if();
    ffa_out_if out_if();
    ffa_cfg_if cfg_if();

    int errors;
    int pending;
    int words_in  = 0;
    int words_out = 0;
    int tx_idle_pct = 18;
    int rx_idle_pct = 86;
    bit stall_req = 1'b0;
    int block_count = 2048;

    logic [CNT_W-1:0] phase_counts [NPHASES] = '{
        12'd2048, 12'd5, 12'd64, 12'd65, 12'd0, 12'd4095,
        12'd1, 12'd129, 12'd2047, 12'd700, 12'd3000, 12'd2048
    };

    always #4 clk = ~clk;

    first_fit_bitmap_block_allocator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    ffa_checker u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_in      (in_if),
        .i_out     (out_if),
        .i_cfg     (cfg_if),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // response side: random ready, one long hold-off on request
    initial begin
        int  hold_left;
        bit  stall_done;
        hold_left = 0;
        stall_done = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (out_if.valid && out_if.ready) words_out++;
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_req && !stall_done) begin
                stall_done = 1'b1;
                hold_left = STALL_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.cmd <= c;
        in_if.block_index <= idx;
        do @(posedge clk); while (!in_if.ready);
        words_in++;
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (words_out < words_in) @(posedge clk);
    endtask

    task automatic write_block_count(input logic [CNT_W-1:0] v);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.total_blocks <= v;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        block_count = int'(v);
    endtask

    initial begin
        #6_000_000;
        $display("first_fit_bitmap_block_allocator test failed");
        $finish;
    end

    initial begin
        int eff;
        int live;
        int span;
        int roll;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.cmd = CMD_ALLOC;
        in_if.block_index = '0;
        cfg_if.valid = 1'b0;
        cfg_if.total_blocks = TOTAL_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first fit, double free, counts 0 / clamp / reduced
        send_word(CMD_ALLOC, '0);
        send_word(CMD_ALLOC, '0);
        send_word(CMD_ALLOC, '1);
        send_word(CMD_FREE, 11'd1);
        send_word(CMD_FREE, 11'd1);
        send_word(CMD_FREE, 11'd2047);
        send_word(CMD_ALLOC, '0);
        send_word(CMD_UNKNOWN, 11'd2047);
        send_word(CMD_FORMAT, '0);
        write_block_count(12'd0);
        send_word(CMD_ALLOC, '0);
        send_word(CMD_FREE, '0);
        send_word(CMD_FORMAT, '0);
        write_block_count(12'd4095);
        send_word(CMD_ALLOC, '0);
        send_word(CMD_FORMAT, '0);
        send_word(CMD_FREE, 11'd2047);
        write_block_count(12'd3);
        send_word(CMD_ALLOC, '0);
        send_word(CMD_ALLOC, '0);
        send_word(CMD_ALLOC, '0);
        send_word(CMD_ALLOC, '0);
        send_word(CMD_FREE, 11'd3);
        write_block_count(12'd2048);
        send_word(CMD_ALLOC, '0);
        write_block_count(12'd2);
        send_word(CMD_FREE, 11'd3);
        send_word(CMD_FREE, 11'd1);
        send_word(CMD_ALLOC, '0);
        send_word(CMD_FREE, '0);

        live = 2;
        for (int p = 0; p < NPHASES; p++) begin
            write_block_count(phase_counts[p]);
            if (p < NPHASES / 3) begin
                tx_idle_pct = 18;
                rx_idle_pct = 86;
            end else if (p < 2 * NPHASES / 3) begin
                tx_idle_pct = 86;
                rx_idle_pct = 18;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == 1) stall_req = 1'b1;
            eff = (block_count > MAX_BLOCKS) ? MAX_BLOCKS : block_count;
            if ($urandom_range(0, 1) == 0) begin
                send_word(CMD_FORMAT, IDX_W'($urandom));
                live = 0;
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                roll = $urandom_range(0, 99);
                span = live + 1;
                if (span > eff) span = eff;
                if (span > MAX_BLOCKS - 1) span = MAX_BLOCKS - 1;
                if (roll < 58) begin
                    send_word(CMD_ALLOC, IDX_W'($urandom));
                    if (live < eff) live++;
                end else if (roll < 88) begin
                    send_word(CMD_FREE, IDX_W'($urandom_range(0, span)));
                    if (live > 0) live--;
                end else if (roll < 94) begin
                    send_word(CMD_FREE, IDX_W'($urandom));
                end else if (roll < 97) begin
                    send_word(CMD_UNKNOWN, IDX_W'($urandom));
                end else begin
                    send_word(CMD_FORMAT, IDX_W'($urandom));
                    live = 0;
                end
            end
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("first_fit_bitmap_block_allocator test passed");
        end else begin
            $display("first_fit_bitmap_block_allocator test failed");
        end
        $finish;
    end

endmodule
